FILE: rtl/rbst_pkg.sv
// ============================================================================
// rbst_pkg: shared types and constants for the ray-box slab test
// Holds the fixed-point widths and the lane-to-merge result structure.
// ============================================================================
`default_nettype none

package rbst_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned AXES   = 3;

    // What one lane reports for its axis.
    typedef struct packed {
        logic              active;
        logic signed [31:0] t_near;
        logic signed [31:0] t_far;
    } t_lane_res;

endpackage

`default_nettype wire

FILE: rtl/rbst_div.sv
// ============================================================================
// rbst_div: pipelined signed restoring divider with saturation
// Divides a signed numerator by a signed 32-bit divisor, one quotient bit per
// stage, truncating toward zero, and clamps the quotient to 32 bits.
// ============================================================================
`default_nettype none

module rbst_div #(
    parameter int unsigned NUM_W = 49
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [NUM_W-1:0]  i_num,
    input  wire logic signed [31:0]       i_den,
    output logic signed [31:0]            o_quo
);
    import rbst_pkg::*;

    localparam int unsigned DEN_W = 33;
    localparam int unsigned REM_W = DEN_W + 1;

    logic [NUM_W-1:0] r_quo  [NUM_W+1];
    logic [REM_W-1:0] r_rem  [NUM_W+1];
    logic [DEN_W-1:0] r_den  [NUM_W+1];
    logic             r_neg  [NUM_W+1];

    logic [NUM_W-1:0] num_abs;
    logic [DEN_W-1:0] den_abs;

    always_comb begin
        num_abs = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        den_abs = i_den[31] ? DEN_W'(-{i_den[31], i_den}) : DEN_W'({1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo[0] <= num_abs;
            r_rem[0] <= '0;
            r_den[0] <= den_abs;
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[31];
        end
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] df;
        always_comb begin
            sh = {r_rem[s][REM_W-2:0], r_quo[s][NUM_W-1]};
            df = sh - REM_W'(r_den[s]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                if (!df[REM_W-1]) begin
                    r_rem[s+1] <= df;
                    r_quo[s+1] <= {r_quo[s][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= sh;
                    r_quo[s+1] <= {r_quo[s][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Saturate the signed magnitude result.
    logic [NUM_W-1:0] mag;
    always_comb begin
        mag = r_quo[NUM_W];
        if (r_neg[NUM_W]) begin
            if (mag > NUM_W'(33'h080000000)) o_quo = 32'sh80000000;
            else                             o_quo = 32'(-mag);
        end else begin
            if (mag > NUM_W'(32'h7FFFFFFF))  o_quo = 32'sh7FFFFFFF;
            else                             o_quo = 32'(mag);
        end
    end
endmodule

`default_nettype wire

FILE: rtl/rbst_lane.sv
// ============================================================================
// rbst_lane: one axis of the slab test
// Forms both scaled corner differences, divides them by the direction and
// orders the two crossings into near and far.
// ============================================================================
`default_nettype none

module rbst_lane #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [31:0]    i_origin,
    input  wire logic signed [31:0]    i_dir,
    input  wire logic signed [31:0]    i_bmin,
    input  wire logic signed [31:0]    i_bmax,
    output rbst_pkg::t_lane_res        o_res
);
    import rbst_pkg::*;

    localparam int unsigned NUM_W = 33 + FRAC_BITS;
    localparam int unsigned LAT   = NUM_W + 1;

    logic signed [NUM_W-1:0] num_a;
    logic signed [NUM_W-1:0] num_b;
    logic signed [31:0]      q_a;
    logic signed [31:0]      q_b;
    logic                    r_act [LAT];

    always_comb begin
        num_a = NUM_W'($signed({i_bmin[31], i_bmin} - {i_origin[31], i_origin})) <<< FRAC_BITS;
        num_b = NUM_W'($signed({i_bmax[31], i_bmax} - {i_origin[31], i_origin})) <<< FRAC_BITS;
    end

    rbst_div #(.NUM_W(NUM_W)) u_div_a (
        .i_clk(i_clk), .i_en(i_en),
        .i_num(num_a), .i_den(i_dir), .o_quo(q_a)
    );
    rbst_div #(.NUM_W(NUM_W)) u_div_b (
        .i_clk(i_clk), .i_en(i_en),
        .i_num(num_b), .i_den(i_dir), .o_quo(q_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act[0] <= (i_dir != '0);
            for (int k = 1; k < LAT; k++) r_act[k] <= r_act[k-1];
        end
    end

    always_comb begin
        o_res.active = r_act[LAT-1];
        o_res.t_near = (q_a < q_b) ? q_a : q_b;
        o_res.t_far  = (q_a < q_b) ? q_b : q_a;
    end
endmodule

`default_nettype wire

FILE: rtl/rbst_merge.sv
// ============================================================================
// rbst_merge: interval narrowing over the three lanes
// Takes the largest near and smallest far crossing of the active lanes, then registers.
// ============================================================================
`default_nettype none

module rbst_merge (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  rbst_pkg::t_lane_res     i_lane [3],
    output logic                    o_hit,
    output logic signed [31:0]      o_t_enter,
    output logic signed [31:0]      o_t_exit
);
    import rbst_pkg::*;

    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;

    always_comb begin
        lo = 32'sh80000000;
        hi = 32'sh7FFFFFFF;
        for (int a = 0; a < AXES; a++) begin
            if (i_lane[a].active) begin
                if (i_lane[a].t_near > lo) lo = i_lane[a].t_near;
                if (i_lane[a].t_far < hi)  hi = i_lane[a].t_far;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= lo;
            r_hi <= hi;
        end
    end

    assign o_t_enter = r_lo;
    assign o_t_exit  = r_hi;
    assign o_hit     = (r_hi >= r_lo);
endmodule

`default_nettype wire

FILE: rtl/ray_box_slab_test.sv
// ============================================================================
// ray_box_slab_test: ray against axis-aligned box, fixed-point slab test
// Three axis lanes divide in pipelined dividers; a merge stage narrows.
// ============================================================================
//
//  Channel | Signals                         | Direction
//  --------+---------------------------------+----------
//  in      | i_valid, o_stall, 12 fields     | into block
//  out     | o_valid, i_stall, hit/t_enter/t_exit | out of block
//
//  One beat is accepted per cycle while the pipeline is not stalled. Its depth is
//  set by the bit-per-stage dividers (one stage per numerator bit) plus the merge.
//  The whole pipeline advances together, so a stall while an output beat is valid
//  freezes every stage and is passed straight back as the input stall.
//  Reset clears only the valid bits of the pipeline.
// ============================================================================
`default_nettype none

module ray_box_slab_test #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_origin_x,
    input  wire logic signed [31:0] i_origin_y,
    input  wire logic signed [31:0] i_origin_z,
    input  wire logic signed [31:0] i_dir_x,
    input  wire logic signed [31:0] i_dir_y,
    input  wire logic signed [31:0] i_dir_z,
    input  wire logic signed [31:0] i_box_min_x,
    input  wire logic signed [31:0] i_box_min_y,
    input  wire logic signed [31:0] i_box_min_z,
    input  wire logic signed [31:0] i_box_max_x,
    input  wire logic signed [31:0] i_box_max_y,
    input  wire logic signed [31:0] i_box_max_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit,
    output logic signed [31:0]      o_t_enter,
    output logic signed [31:0]      o_t_exit
);
    import rbst_pkg::*;

    // Divider stages plus the operand stage and the merge register.
    localparam int unsigned LAT = 35 + FRAC_BITS;

    logic            en;
    logic [LAT-1:0]  r_vld;
    t_lane_res       lane_res [3];

    // The pipeline moves whenever the output side is not holding a beat.
    assign en      = !(i_stall && r_vld[LAT-1]);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .i_clk(i_clk), .i_en(en),
        .i_origin(i_origin_x), .i_dir(i_dir_x),
        .i_bmin(i_box_min_x), .i_bmax(i_box_max_x), .o_res(lane_res[0])
    );
    rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .i_clk(i_clk), .i_en(en),
        .i_origin(i_origin_y), .i_dir(i_dir_y),
        .i_bmin(i_box_min_y), .i_bmax(i_box_max_y), .o_res(lane_res[1])
    );
    rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .i_clk(i_clk), .i_en(en),
        .i_origin(i_origin_z), .i_dir(i_dir_z),
        .i_bmin(i_box_min_z), .i_bmax(i_box_max_z), .o_res(lane_res[2])
    );

    rbst_merge u_merge (
        .i_clk(i_clk), .i_en(en), .i_lane(lane_res),
        .o_hit(o_hit), .o_t_enter(o_t_enter), .o_t_exit(o_t_exit)
    );

    // A held result beat must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_t_enter) && $stable(o_t_exit)))
        else $error("held result changed");
    // Stall is only raised while a result waits.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_stall |-> o_valid)
        else $error("stall without pending result");
    // Hit agrees with the interval ends.
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit == (o_t_exit >= o_t_enter)))
        else $error("hit flag inconsistent");
endmodule

`default_nettype wire
